FILE: sv/min_delete_sum_weighted_lcs_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted LCS delete-sum block
// Shared helpers for writing concurrent assertions in one line.
// ----------------------------------------------------------------------------
`ifndef MIN_DELETE_SUM_WEIGHTED_LCS_DEFINES_SVH
`define MIN_DELETE_SUM_WEIGHTED_LCS_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define MDSWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define MDSWL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/mdswl_pkg.sv
// ----------------------------------------------------------------------------
// mdswl_pkg
// Types and codes shared by the weighted LCS delete-sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package mdswl_pkg;

    localparam int DS_W   = 19;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_CELL,
        S_FINAL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic row_start;
        logic cell_step;
        logic next_row;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic i_last;
        logic j_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: sv/min_delete_sum_weighted_lcs.sv
// Loads two byte strings one beat at a time (kind 0 to string A, kind 1 to
// string B) at one beat per cycle; a kind 2 beat computes the minimum delete
// sum of the two strings, returns one result beat and clears both strings.
// A compute is done by the row-store sweep that updates one table cell per
// cycle (skipped when either string is empty); input is stalled meanwhile.
// Bytes beyond MAXLEN are dropped and reported in truncated. No clearing pass
// follows reset.
// ----------------------------------------------------------------------------
// min_delete_sum_weighted_lcs
// Top level: sequencer plus datapath for the weighted LCS delete sum.
// ----------------------------------------------------------------------------
`default_nettype none

module min_delete_sum_weighted_lcs #(
    parameter int MAXLEN = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [mdswl_pkg::KIND_W-1:0]   kind,
    input  wire logic [mdswl_pkg::CHAR_W-1:0]   char_value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [mdswl_pkg::DS_W-1:0]          delete_sum,
    output logic                                truncated
);

    mdswl_pkg::cmd_t    cmd;
    mdswl_pkg::status_t status;

    mdswl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mdswl_dp #(.MAXLEN(MAXLEN)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .char_value (char_value),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .delete_sum (delete_sum),
        .truncated  (truncated)
    );

endmodule

`default_nettype wire

FILE: sv/mdswl_ram.sv
// ----------------------------------------------------------------------------
// mdswl_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mdswl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/mdswl_ctrl.sv
// ----------------------------------------------------------------------------
// mdswl_ctrl
// Sequencer: load handshake, row/cell sweep of the table, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mdswl_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic [mdswl_pkg::KIND_W-1:0]        kind,
    output logic                                     in_stall,
    input  wire mdswl_pkg::status_t                  status,
    output mdswl_pkg::cmd_t                          cmd
);

    mdswl_pkg::state_t state_reg;
    mdswl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mdswl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mdswl_pkg::S_IDLE:
            begin
                if (in_valid && kind == mdswl_pkg::KIND_COMPUTE)
                begin
                    state_next = status.empty ? mdswl_pkg::S_OUT : mdswl_pkg::S_ROW;
                end
            end
            mdswl_pkg::S_ROW:
            begin
                state_next = mdswl_pkg::S_CELL;
            end
            mdswl_pkg::S_CELL:
            begin
                if (status.j_last)
                begin
                    state_next = status.i_last ? mdswl_pkg::S_FINAL : mdswl_pkg::S_ROW;
                end
            end
            mdswl_pkg::S_FINAL:
            begin
                state_next = mdswl_pkg::S_OUT;
            end
            mdswl_pkg::S_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = mdswl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mdswl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            mdswl_pkg::S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.load_a = in_valid && kind == mdswl_pkg::KIND_LOAD_A;
                cmd.load_b = in_valid && kind == mdswl_pkg::KIND_LOAD_B;
                cmd.start  = in_valid && kind == mdswl_pkg::KIND_COMPUTE;
            end
            mdswl_pkg::S_ROW:
            begin
                cmd.row_start = 1'b1;
            end
            mdswl_pkg::S_CELL:
            begin
                cmd.cell_step = 1'b1;
                cmd.next_row  = status.j_last && !status.i_last;
            end
            mdswl_pkg::S_FINAL:
            begin
                cmd = '0;
            end
            mdswl_pkg::S_OUT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/mdswl_dp.sv
// ----------------------------------------------------------------------------
// mdswl_dp
// Datapath: string and row stores, sums, lengths, cell update, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module mdswl_dp #(
    parameter int MAXLEN = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mdswl_pkg::cmd_t                    cmd,
    output mdswl_pkg::status_t                      status,
    input  wire logic [mdswl_pkg::CHAR_W-1:0]       char_value,
    input  wire logic                               out_stall,
    output logic                                    out_valid,
    output logic [mdswl_pkg::DS_W-1:0]              delete_sum,
    output logic                                    truncated
);

    localparam int LEN_W  = $clog2(MAXLEN + 1);
    localparam int STR_AW = MAXLEN > 1 ? $clog2(MAXLEN) : 1;
    localparam int SUM_W  = $clog2(MAXLEN * 255 + 1);
    localparam int TOT_W  = SUM_W + 1;
    localparam int EXT_W  = TOT_W > mdswl_pkg::DS_W ? TOT_W : mdswl_pkg::DS_W;

    logic [LEN_W-1:0]  len_a_reg, len_a_next;
    logic [LEN_W-1:0]  len_b_reg, len_b_next;
    logic [SUM_W-1:0]  sum_a_reg, sum_a_next;
    logic [SUM_W-1:0]  sum_b_reg, sum_b_next;
    logic              ovf_reg, ovf_next;
    logic [STR_AW-1:0] i_reg, i_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic              calc_v_reg, calc_v_next;
    logic              first_reg, first_next;
    logic [LEN_W-1:0]  calc_j_reg, calc_j_next;
    logic [SUM_W-1:0]  left_reg, left_next;
    logic [SUM_W-1:0]  diag_reg, diag_next;
    logic              out_valid_reg, out_valid_next;
    logic [mdswl_pkg::DS_W-1:0] delete_sum_reg, delete_sum_next;
    logic              truncated_reg, truncated_next;

    logic                        wr_a, wr_b;
    logic [STR_AW-1:0]           b_raddr;
    logic [LEN_W-1:0]            j_m1;
    logic [mdswl_pkg::CHAR_W-1:0] ca, cb;
    logic [SUM_W-1:0]            up, row_rdata, cell_val;
    logic [EXT_W-1:0]            total;

    assign wr_a    = cmd.load_a && len_a_reg < LEN_W'(MAXLEN);
    assign wr_b    = cmd.load_b && len_b_reg < LEN_W'(MAXLEN);
    assign j_m1    = j_reg - LEN_W'(1);
    assign b_raddr = STR_AW'(j_m1);

    mdswl_ram #(.WIDTH(mdswl_pkg::CHAR_W), .DEPTH(MAXLEN)) u_str_a (
        .clk   (clk),
        .we    (wr_a),
        .waddr (STR_AW'(len_a_reg)),
        .wdata (char_value),
        .re    (cmd.row_start),
        .raddr (i_reg),
        .rdata (ca)
    );

    mdswl_ram #(.WIDTH(mdswl_pkg::CHAR_W), .DEPTH(MAXLEN)) u_str_b (
        .clk   (clk),
        .we    (wr_b),
        .waddr (STR_AW'(len_b_reg)),
        .wdata (char_value),
        .re    (cmd.cell_step),
        .raddr (b_raddr),
        .rdata (cb)
    );

    mdswl_ram #(.WIDTH(SUM_W), .DEPTH(MAXLEN + 1)) u_row (
        .clk   (clk),
        .we    (calc_v_reg),
        .waddr (calc_j_reg),
        .wdata (cell_val),
        .re    (cmd.cell_step),
        .raddr (j_reg),
        .rdata (row_rdata)
    );

    // first row reads as all zero, so the row store needs no clearing pass
    assign up       = first_reg ? '0 : row_rdata;
    assign cell_val = (ca == cb) ? diag_reg + SUM_W'(ca)
                                 : ((up > left_reg) ? up : left_reg);
    assign total    = EXT_W'(sum_a_reg) + EXT_W'(sum_b_reg) - (EXT_W'(left_reg) << 1);

    assign status.empty    = len_a_reg == '0 || len_b_reg == '0;
    assign status.i_last   = LEN_W'(i_reg) + LEN_W'(1) == len_a_reg;
    assign status.j_last   = j_reg == len_b_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        len_a_next      = len_a_reg;
        len_b_next      = len_b_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        calc_v_next     = cmd.cell_step;
        first_next      = i_reg == '0;
        calc_j_next     = j_reg;
        left_next       = left_reg;
        diag_next       = diag_reg;
        out_valid_next  = out_valid_reg && out_stall;
        delete_sum_next = delete_sum_reg;
        truncated_next  = truncated_reg;

        if (wr_a)
        begin
            len_a_next = len_a_reg + LEN_W'(1);
            sum_a_next = sum_a_reg + SUM_W'(char_value);
        end
        if (wr_b)
        begin
            len_b_next = len_b_reg + LEN_W'(1);
            sum_b_next = sum_b_reg + SUM_W'(char_value);
        end
        if ((cmd.load_a && !wr_a) || (cmd.load_b && !wr_b))
        begin
            ovf_next = 1'b1;
        end

        if (calc_v_reg)
        begin
            left_next = cell_val;
            diag_next = up;
        end
        if (cmd.start || cmd.row_start)
        begin
            left_next = '0;
            diag_next = '0;
        end
        if (cmd.start)
        begin
            i_next = '0;
        end
        if (cmd.row_start)
        begin
            j_next = LEN_W'(1);
        end
        if (cmd.cell_step)
        begin
            j_next = j_reg + LEN_W'(1);
        end
        if (cmd.next_row)
        begin
            i_next = i_reg + STR_AW'(1);
        end

        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            delete_sum_next = total[mdswl_pkg::DS_W-1:0];
            truncated_next  = ovf_reg;
            len_a_next      = '0;
            len_b_next      = '0;
            sum_a_next      = '0;
            sum_b_next      = '0;
            ovf_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            calc_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_a_reg     <= len_a_next;
            len_b_reg     <= len_b_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            ovf_reg       <= ovf_next;
            calc_v_reg    <= calc_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        first_reg      <= first_next;
        calc_j_reg     <= calc_j_next;
        left_reg       <= left_next;
        diag_reg       <= diag_next;
        delete_sum_reg <= delete_sum_next;
        truncated_reg  <= truncated_next;
    end

    assign out_valid  = out_valid_reg;
    assign delete_sum = delete_sum_reg;
    assign truncated  = truncated_reg;

endmodule

`default_nettype wire

FILE: sv/mdswl_checker.sv
// ----------------------------------------------------------------------------
// mdswl_checker
// Port-level checks on the weighted LCS delete-sum block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_delete_sum_weighted_lcs_defines.svh"

module mdswl_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire logic [mdswl_pkg::KIND_W-1:0]   kind,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [mdswl_pkg::DS_W-1:0]     delete_sum,
    input wire logic                           truncated
);

    logic load_beat;
    logic compute_beat;
    logic [mdswl_pkg::DS_W:0] out_beat;

    assign load_beat    = in_valid && !in_stall &&
                          (kind == mdswl_pkg::KIND_LOAD_A || kind == mdswl_pkg::KIND_LOAD_B);
    assign compute_beat = in_valid && !in_stall && kind == mdswl_pkg::KIND_COMPUTE;
    assign out_beat     = {delete_sum, truncated};

    `MDSWL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_beat))
    `MDSWL_ASSERT_NEXT(a_compute_stalls, clk, rst_n, compute_beat, in_stall)
    `MDSWL_ASSERT_NEXT(a_load_keeps_open, clk, rst_n, load_beat, !in_stall)
    `MDSWL_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind min_delete_sum_weighted_lcs mdswl_checker u_checker (.*);

`default_nettype wire
